@@ design/gwpu_pkg.sv @@
// Package for the grey wolf position update block.
// Holds fixed-point widths, configuration codes, the job record and generator types.
// No dependencies.
package gwpu_pkg;

    localparam int POS_W  = 32;
    localparam int FRAC_W = 16;
    localparam int RAND_W = 16;
    localparam int A_W    = FRAC_W + 2;
    localparam int RNG_W  = 64;

    localparam logic [RNG_W-1:0] SEED_MIX_LOW  = 64'h0123456789ABCDEF;
    localparam logic [RNG_W-1:0] SEED_MIX_HIGH = 64'hFEDCBA9876543210;
    localparam logic [A_W-1:0]   A_RESET       = A_W'(1) << (FRAC_W + 1);

    localparam int CFG_W = 1;
    localparam logic [CFG_W-1:0] CFG_COEF_A = 1'b0;
    localparam logic [CFG_W-1:0] CFG_SEED   = 1'b1;

    localparam int N_LEAD = 3;
    localparam int LEAD_W = $clog2(N_LEAD);

    localparam int COEF_W = A_W + 2;
    localparam int PA_W   = A_W + 1 + RAND_W;
    localparam int PC_W   = POS_W + RAND_W + 2;
    localparam int CL_W   = PC_W - RAND_W;
    localparam int D_W    = CL_W + 1;
    localparam int PD_W   = COEF_W + D_W + 1;
    localparam int XT_W   = PD_W - FRAC_W;
    localparam int X_W    = XT_W + 1;
    localparam int SUM_W  = X_W + 2;

    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [POS_W-1:0]                position;
        logic [N_LEAD-1:0][POS_W-1:0]    leader;
        logic [POS_W-1:0]                lower_bound;
        logic [POS_W-1:0]                upper_bound;
        logic [N_LEAD-1:0][RAND_W-1:0]   r1;
        logic [N_LEAD-1:0][RAND_W-1:0]   r2;
    } t_job;

    typedef struct packed {
        logic [RNG_W-1:0] low;
        logic [RNG_W-1:0] high;
    } t_rng;

    typedef struct packed {
        t_rng              state;
        logic [RAND_W-1:0] value;
    } t_draw;

endpackage

@@ design/gwpu_front.sv @@
// Front end: accepts one coordinate beat, draws the six uniforms, hands a job to the queue.
// Owns the xorshift128+ generator state. Depends on gwpu_pkg.
module gwpu_front
    import gwpu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [POS_W-1:0] i_position,
    input  logic [POS_W-1:0] i_alpha_position,
    input  logic [POS_W-1:0] i_beta_position,
    input  logic [POS_W-1:0] i_delta_position,
    input  logic [POS_W-1:0] i_lower_bound,
    input  logic [POS_W-1:0] i_upper_bound,
    input  logic             i_seed_we,
    input  logic [RNG_W-1:0] i_seed,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output t_job             o_job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DRAW = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    function automatic t_draw draw(input t_rng s);
        logic [RNG_W-1:0] s1;
        logic [RNG_W-1:0] s0;
        logic [RNG_W-1:0] nh;
        t_draw            d;
        s1 = s.low;
        s0 = s.high;
        s1 = s1 ^ (s1 << 23);
        nh = s1 ^ s0 ^ (s1 >> 17) ^ (s0 >> 26);
        d.state.low  = s0;
        d.state.high = nh;
        d.value      = RAND_W'((nh + s0) >> (RNG_W - RAND_W));
        return d;
    endfunction

    logic [1:0]        r_state;
    logic [LEAD_W-1:0] r_k;
    t_rng              r_rng;
    t_job              r_job;
    t_draw             d1;
    t_draw             d2;

    always_comb begin
        d1 = draw(r_rng);
        d2 = draw(d1.state);
    end

    assign o_in_ready  = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_k        <= '0;
            r_rng.low  <= SEED_MIX_LOW;
            r_rng.high <= SEED_MIX_HIGH;
        end else begin
            if (i_seed_we) begin
                r_rng.low  <= i_seed ^ SEED_MIX_LOW;
                r_rng.high <= i_seed ^ SEED_MIX_HIGH;
            end else if (r_state == F_DRAW) begin
                r_rng <= d2.state;
            end
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_k     <= '0;
                        r_state <= F_DRAW;
                    end
                end
                F_DRAW: begin
                    if (r_k == LEAD_W'(N_LEAD - 1)) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_job.position    <= i_position;
            r_job.leader[0]   <= i_alpha_position;
            r_job.leader[1]   <= i_beta_position;
            r_job.leader[2]   <= i_delta_position;
            r_job.lower_bound <= i_lower_bound;
            r_job.upper_bound <= i_upper_bound;
        end
        if (r_state == F_DRAW) begin
            r_job.r1[r_k] <= d1.value;
            r_job.r2[r_k] <= d2.value;
        end
    end

endmodule

@@ design/gwpu_queue.sv @@
// Two-entry job queue between the front end and the arithmetic back end.
// Depends on gwpu_pkg.
module gwpu_queue
    import gwpu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(Q_DEPTH))
        else $error("queue count above depth");

endmodule

@@ design/gwpu_back.sv @@
// Back end: per-leader pull arithmetic on shared multipliers, divide by three,
// saturate and clamp, output register. Depends on gwpu_pkg.
module gwpu_back
    import gwpu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [A_W-1:0]   i_coef_a,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  t_job             i_job,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [POS_W-1:0] o_new_position
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_DIST = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]               r_state;
    logic [LEAD_W-1:0]        r_k;
    logic [DCNT_W-1:0]        r_cnt;
    t_job                     r_job;
    logic signed [COEF_W-1:0] r_coef;
    logic signed [CL_W-1:0]   r_cl;
    logic [D_W-1:0]           r_dist;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_neg;
    logic [DIV_W-1:0]         r_mag;
    logic [1:0]               r_rem;
    logic                     r_out_valid;
    logic [POS_W-1:0]         r_out_data;

    logic signed [POS_W-1:0]  lead;
    logic [RAND_W-1:0]        r1;
    logic [RAND_W-1:0]        r2;
    logic [PA_W-1:0]          prod_a;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [RAND_W+1:0] c_op;
    logic signed [PC_W-1:0]   prod_c;
    logic signed [D_W-1:0]    diff;
    logic [D_W-1:0]           dist_mag;
    logic signed [PD_W-1:0]   prod_d;
    logic signed [XT_W-1:0]   pull;
    logic signed [X_W-1:0]    x_val;
    logic signed [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]         sum_mag;
    logic [1:0]               rem;
    logic [2:0]               trial;
    logic [DIV_BITS-1:0]      dbits;
    logic [DIV_BITS-1:0]      qbits;
    logic [DIV_W-1:0]         n_mag;
    logic [SUM_W-1:0]         quo;
    logic signed [SUM_W:0]    sq;
    logic signed [SUM_W:0]    sat_hi;
    logic signed [SUM_W:0]    sat_lo;
    logic signed [POS_W-1:0]  sat;
    logic signed [POS_W-1:0]  result;
    logic                     load_out;

    always_comb begin
        lead     = $signed(r_job.leader[r_k]);
        r1       = r_job.r1[r_k];
        r2       = r_job.r2[r_k];
        prod_a   = PA_W'({i_coef_a, 1'b0}) * PA_W'(r1);
        coef_a   = $signed({1'b0, prod_a[PA_W-1:RAND_W]}) - $signed({2'b00, i_coef_a});
        c_op     = $signed({1'b0, r2, 1'b0});
        prod_c   = PC_W'(lead) * PC_W'(c_op);
        diff     = D_W'(r_cl) - D_W'($signed(r_job.position));
        dist_mag = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
        prod_d   = PD_W'(r_coef) * PD_W'($signed({1'b0, r_dist}));
        pull     = prod_d[PD_W-1:FRAC_W];
        x_val    = X_W'(lead) - X_W'(pull);
        n_sum    = r_sum + SUM_W'(x_val);
        sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    end

    always_comb begin
        rem   = r_rem;
        dbits = r_mag[DIV_W-1 -: DIV_BITS];
        qbits = '0;
        trial = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            trial = {rem, dbits[i]};
            if (trial >= 3'd3) begin
                qbits[i] = 1'b1;
                rem      = 2'(trial - 3'd3);
            end else begin
                qbits[i] = 1'b0;
                rem      = trial[1:0];
            end
        end
        n_mag = {r_mag[DIV_W-DIV_BITS-1:0], qbits};
    end

    always_comb begin
        quo    = r_mag[SUM_W-1:0];
        sq     = r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        sat_hi = (SUM_W + 1)'($signed({1'b0, {(POS_W - 1){1'b1}}}));
        sat_lo = (SUM_W + 1)'($signed({1'b1, {(POS_W - 1){1'b0}}}));
        priority if (sq > sat_hi) begin
            sat = sat_hi[POS_W-1:0];
        end else if (sq < sat_lo) begin
            sat = sat_lo[POS_W-1:0];
        end else begin
            sat = sq[POS_W-1:0];
        end
        priority if (sat < $signed(r_job.lower_bound)) begin
            result = $signed(r_job.lower_bound);
        end else if (sat > $signed(r_job.upper_bound)) begin
            result = $signed(r_job.upper_bound);
        end else begin
            result = sat;
        end
    end

    assign load_out       = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_job_ready    = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_new_position = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_k     <= '0;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_DIST;
                S_DIST: r_state <= S_MUL2;
                S_MUL2: begin
                    if (r_k == LEAD_W'(N_LEAD - 1)) begin
                        r_state <= S_PREP;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL1;
                    end
                end
                S_PREP: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_job <= i_job;
            r_sum <= '0;
        end
        if (r_state == S_MUL1) begin
            r_coef <= coef_a;
            r_cl   <= prod_c[PC_W-1:RAND_W];
        end
        if (r_state == S_DIST) begin
            r_dist <= dist_mag;
        end
        if (r_state == S_MUL2) begin
            r_sum <= n_sum;
        end
        if (r_state == S_PREP) begin
            r_neg <= r_sum[SUM_W-1];
            r_mag <= DIV_W'(sum_mag);
            r_rem <= '0;
        end
        if (r_state == S_DIV) begin
            r_mag <= n_mag;
            r_rem <= rem;
        end
        if (load_out) begin
            r_out_data <= result;
        end
    end

    a_lead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= LEAD_W'(N_LEAD - 1))
        else $error("leader index out of range");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < DCNT_W'(DIV_STEPS)))
        else $error("divide step count overrun");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem != 2'd3))
        else $error("divide remainder not below three");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after load");

endmodule

@@ design/grey_wolf_position_update.sv @@
// Grey wolf position update: one coordinate of one agent per input beat.
// Input channel i_in_valid/o_in_ready carries the position, the alpha, beta and
// delta leader coordinates and the bounds, all signed Q16.16. Output channel
// o_out_valid/i_out_ready carries the new coordinate, one beat per input beat.
// Configuration: i_cfg_we with i_cfg_index selects coefficient a (Q2.16) or the
// 64-bit seed; a seed write reloads both generator words. Write only while idle.
// The back end sequencer takes a new beat only while idle, then makes one pass per
// leader over its shared multipliers (coefficients, distance, pull and sum), a
// radix-256 divide by three and the result load. The front end draws the uniforms
// for one beat at a time, taking no new beat until it hands the job on, and a
// two-entry queue decouples the two sides.
// Reset: a = 2.0, generator words at their seed-zero values, queue and output empty.
// When the receiver stalls, the result holds in the output register, the back end
// finishes the next beat and waits, and the front end keeps filling the queue.
// Depends on gwpu_pkg, gwpu_front, gwpu_queue, gwpu_back.
module grey_wolf_position_update
    import gwpu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [POS_W-1:0] i_position,
    input  logic [POS_W-1:0] i_alpha_position,
    input  logic [POS_W-1:0] i_beta_position,
    input  logic [POS_W-1:0] i_delta_position,
    input  logic [POS_W-1:0] i_lower_bound,
    input  logic [POS_W-1:0] i_upper_bound,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [POS_W-1:0] o_new_position,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_index,
    input  logic [RNG_W-1:0] i_cfg_data
);

    logic [A_W-1:0] r_coef_a;
    logic           seed_we;
    logic           f_valid;
    logic           f_ready;
    t_job           f_job;
    logic           b_valid;
    logic           b_ready;
    t_job           b_job;

    assign seed_we = i_cfg_we && (i_cfg_index == CFG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= A_RESET;
        end else if (i_cfg_we && i_cfg_index == CFG_COEF_A) begin
            r_coef_a <= i_cfg_data[A_W-1:0];
        end
    end

    gwpu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_position       (i_position),
        .i_alpha_position (i_alpha_position),
        .i_beta_position  (i_beta_position),
        .i_delta_position (i_delta_position),
        .i_lower_bound    (i_lower_bound),
        .i_upper_bound    (i_upper_bound),
        .i_seed_we        (seed_we),
        .i_seed           (i_cfg_data),
        .o_job_valid      (f_valid),
        .i_job_ready      (f_ready),
        .o_job            (f_job)
    );

    gwpu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_job),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (b_job)
    );

    gwpu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_coef_a       (r_coef_a),
        .i_job_valid    (b_valid),
        .o_job_ready    (b_ready),
        .i_job          (b_job),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_new_position (o_new_position)
    );

endmodule

@@ test/grey_wolf_position_update_check.sv @@
// Checker for grey_wolf_position_update: watches the input, output and register ports,
// predicts each new coordinate and compares it with what the block returns.
// Depends on gwpu_pkg.
module grey_wolf_position_update_check
    import gwpu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [POS_W-1:0] i_position,
    input  logic [POS_W-1:0] i_alpha_position,
    input  logic [POS_W-1:0] i_beta_position,
    input  logic [POS_W-1:0] i_delta_position,
    input  logic [POS_W-1:0] i_lower_bound,
    input  logic [POS_W-1:0] i_upper_bound,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [POS_W-1:0] i_new_position,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_index,
    input  logic [RNG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [A_W-1:0]   coef_a;
    logic [RNG_W-1:0] rng_low;
    logic [RNG_W-1:0] rng_high;
    logic [POS_W-1:0] expected_positions[$];

    function automatic logic [RAND_W-1:0] next_uniform();
        logic [RNG_W-1:0] s1;
        logic [RNG_W-1:0] s0;
        logic [RNG_W-1:0] sum;
        s1 = rng_low;
        s0 = rng_high;
        rng_low = s0;
        s1 = s1 ^ (s1 << 23);
        rng_high = s1 ^ s0 ^ (s1 >> 17) ^ (s0 >> 26);
        sum = rng_high + s0;
        return sum[RNG_W-1 -: RAND_W];
    endfunction

    function automatic longint pull_toward(longint leader, longint pos);
        longint r1;
        longint r2;
        longint a;
        longint coef_big_a;
        longint coef_c;
        longint gap;
        r1 = longint'(next_uniform());
        r2 = longint'(next_uniform());
        a = longint'(coef_a);
        coef_big_a = ((2 * a * r1) >>> RAND_W) - a;
        coef_c = 2 * r2;
        gap = ((coef_c * leader) >>> RAND_W) - pos;
        if (gap < 0) begin
            gap = -gap;
        end
        return leader - ((coef_big_a * gap) >>> FRAC_W);
    endfunction

    function automatic logic [POS_W-1:0] predict_new_position(
        logic [POS_W-1:0] pos_bits,
        logic [POS_W-1:0] alpha_bits,
        logic [POS_W-1:0] beta_bits,
        logic [POS_W-1:0] delta_bits,
        logic [POS_W-1:0] lo_bits,
        logic [POS_W-1:0] hi_bits
    );
        longint pos;
        longint x1;
        longint x2;
        longint x3;
        longint x;
        longint lb;
        longint ub;
        longint sat_hi;
        longint sat_lo;
        pos = longint'($signed(pos_bits));
        lb = longint'($signed(lo_bits));
        ub = longint'($signed(hi_bits));
        x1 = pull_toward(longint'($signed(alpha_bits)), pos);
        x2 = pull_toward(longint'($signed(beta_bits)), pos);
        x3 = pull_toward(longint'($signed(delta_bits)), pos);
        x = (x1 + x2 + x3) / 3;
        sat_hi = (longint'(1) <<< (POS_W - 1)) - 1;
        sat_lo = -sat_hi - 1;
        if (x > sat_hi) begin
            x = sat_hi;
        end
        if (x < sat_lo) begin
            x = sat_lo;
        end
        if (x < lb) begin
            x = lb;
        end else if (x > ub) begin
            x = ub;
        end
        return x[POS_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [POS_W-1:0] want;
        if (!i_rst_n) begin
            coef_a = A_RESET;
            rng_low = SEED_MIX_LOW;
            rng_high = SEED_MIX_HIGH;
            expected_positions.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_COEF_A) begin
                    coef_a = i_cfg_data[A_W-1:0];
                end else if (i_cfg_index == CFG_SEED) begin
                    rng_low = i_cfg_data ^ SEED_MIX_LOW;
                    rng_high = i_cfg_data ^ SEED_MIX_HIGH;
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_positions.push_back(predict_new_position(i_position,
                    i_alpha_position, i_beta_position, i_delta_position,
                    i_lower_bound, i_upper_bound));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_positions.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result beat: new_position %0d",
                                 $signed(i_new_position));
                    end
                end else begin
                    want = expected_positions.pop_front();
                    if (i_new_position !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("new_position mismatch at result %0d: expected %0d, got %0d",
                                     o_checked, $signed(want), $signed(i_new_position));
                        end
                    end
                end
                o_checked++;
            end
        end
        o_pending = expected_positions.size();
    end

endmodule

@@ test/grey_wolf_position_update_test.sv @@
// Top of the grey_wolf_position_update testbench: clock, reset, register writes,
// directed and random coordinate beats, output back-pressure and the verdict.
// Depends on gwpu_pkg, grey_wolf_position_update and grey_wolf_position_update_check.
module grey_wolf_position_update_test
    import gwpu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [POS_W-1:0] CMIN = {1'b1, {(POS_W - 1){1'b0}}};
    localparam logic [POS_W-1:0] CMAX = ~CMIN;
    localparam logic [POS_W-1:0] ONE  = POS_W'(1) << FRAC_W;
    localparam logic [A_W-1:0]   A_MAX = '1;
    localparam int               PHASE_BEATS = 180;
    localparam int               CYCLE_LIMIT = 500000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [POS_W-1:0] i_position;
    logic [POS_W-1:0] i_alpha_position;
    logic [POS_W-1:0] i_beta_position;
    logic [POS_W-1:0] i_delta_position;
    logic [POS_W-1:0] i_lower_bound;
    logic [POS_W-1:0] i_upper_bound;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [POS_W-1:0] o_new_position;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_index;
    logic [RNG_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int beats_in;
    int settings;
    int in_idle_pct;
    int out_idle_pct;
    int cycles;
    bit held_off;

    grey_wolf_position_update dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_position      (i_position),
        .i_alpha_position(i_alpha_position),
        .i_beta_position (i_beta_position),
        .i_delta_position(i_delta_position),
        .i_lower_bound   (i_lower_bound),
        .i_upper_bound   (i_upper_bound),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_new_position  (o_new_position),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    grey_wolf_position_update_check checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_position      (i_position),
        .i_alpha_position(i_alpha_position),
        .i_beta_position (i_beta_position),
        .i_delta_position(i_delta_position),
        .i_lower_bound   (i_lower_bound),
        .i_upper_bound   (i_upper_bound),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_new_position  (o_new_position),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial i_clk = 1'b0;
    always #1ns i_clk = ~i_clk;

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("grey_wolf_position_update test failed");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off to back the block up
    initial begin
        i_out_ready = 1'b0;
        held_off = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && beats_in >= 250) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < out_idle_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] alpha,
                             input logic [POS_W-1:0] beta, input logic [POS_W-1:0] delta,
                             input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
        i_in_valid <= 1'b1;
        i_position <= pos;
        i_alpha_position <= alpha;
        i_beta_position <= beta;
        i_delta_position <= delta;
        i_lower_bound <= lo;
        i_upper_bound <= hi;
        do @(posedge i_clk); while (!o_in_ready);
        beats_in++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [RNG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] pick_coord();
        int v;
        case ($urandom_range(0, 9))
            0: return CMIN;
            1: return CMAX;
            2, 3, 4, 5: return POS_W'($urandom);
            default: begin
                v = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                return POS_W'(v);
            end
        endcase
    endfunction

    task automatic run_phase(input int count, input logic [A_W-1:0] a,
                             input logic [RNG_W-1:0] seed_val,
                             input int in_pct, input int out_pct);
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [POS_W-1:0] u;
        logic [POS_W-1:0] w;
        drain();
        write_reg(CFG_COEF_A, RNG_W'(a));
        write_reg(CFG_SEED, seed_val);
        settings++;
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        for (int n = 0; n < count; n++) begin
            u = pick_coord();
            w = pick_coord();
            case ($urandom_range(0, 7))
                0: begin
                    lo = CMIN;
                    hi = CMAX;
                end
                1: begin
                    // crossed bounds
                    lo = ($signed(u) > $signed(w)) ? u : w;
                    hi = ($signed(u) > $signed(w)) ? w : u;
                end
                default: begin
                    lo = ($signed(u) < $signed(w)) ? u : w;
                    hi = ($signed(u) < $signed(w)) ? w : u;
                end
            endcase
            send_beat(pick_coord(), pick_coord(), pick_coord(), pick_coord(), lo, hi);
            if ($urandom_range(0, 99) < in_idle_pct) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_position = '0;
        i_alpha_position = '0;
        i_beta_position = '0;
        i_delta_position = '0;
        i_lower_bound = '0;
        i_upper_bound = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_COEF_A;
        i_cfg_data = '0;
        beats_in = 0;
        settings = 1;
        in_idle_pct = 0;
        out_idle_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values of a and the generator
        send_beat('0, '0, '0, '0, CMIN, CMAX);
        send_beat(ONE, 2 * ONE, 3 * ONE, -ONE, CMIN, CMAX);
        send_beat(CMAX, CMAX, CMAX, CMAX, CMIN, CMAX);
        send_beat(CMIN, CMIN, CMIN, CMIN, CMIN, CMAX);
        send_beat(CMIN, CMAX, CMAX, CMAX, CMIN, CMAX);
        send_beat(CMAX, CMIN, CMIN, CMIN, CMIN, CMAX);
        send_beat('0, ONE, -ONE, ONE >> 1, 10 * ONE, -10 * ONE);
        send_beat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 5 * ONE);
        drain();

        // largest a: saturation and crossed bounds
        write_reg(CFG_COEF_A, RNG_W'(A_MAX));
        write_reg(CFG_SEED, '1);
        settings++;
        send_beat(CMIN, CMAX, CMAX, CMAX, CMIN, CMAX);
        send_beat(CMAX, CMIN, CMIN, CMIN, CMIN, CMAX);
        send_beat('0, CMAX, CMAX, CMAX, CMIN, CMAX);
        send_beat('0, CMIN, CMIN, CMIN, CMIN, CMAX);
        send_beat('0, ONE, 2 * ONE, -ONE, CMAX, CMIN);
        send_beat('0, ONE >> 1, ONE >> 1, ONE >> 1, ONE, -ONE);
        send_beat('0, 100 * ONE, 100 * ONE, 100 * ONE, -(ONE >> 1), ONE >> 1);
        send_beat('0, '0, '0, '0, CMIN, CMAX);
        send_beat('1, ONE, ONE, ONE, CMIN, CMAX);
        send_beat(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);

        run_phase(PHASE_BEATS, A_W'($urandom_range(0, (1 << A_W) - 1)),
                  {$urandom, $urandom}, 30, 5);
        run_phase(PHASE_BEATS, '0, '0, 0, 0);
        run_phase(PHASE_BEATS, A_RESET, {$urandom, $urandom}, 50, 10);
        run_phase(PHASE_BEATS, A_W'(1), '1, 20, 3);
        run_phase(PHASE_BEATS, A_W'($urandom_range(0, (1 << A_W) - 1)),
                  {$urandom, $urandom}, 40, 8);
        run_phase(PHASE_BEATS, A_MAX, {$urandom, $urandom}, 0, 0);

        drain();
        repeat (40) @(negedge i_clk);
        $display("Sent %0d coordinate beats under %0d settings of a and the seed;",
                 beats_in, settings);
        $display("compared %0d updated positions, including a long output hold-off.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("grey_wolf_position_update test passed");
        end else begin
            $display("grey_wolf_position_update test failed");
        end
        $finish;
    end

endmodule
